### src/ptto_pkg.sv
`timescale 1ns / 1ps

package ptto_pkg;

    // One input item: request code and world-time sample.
    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] sample_sec;
        logic [19:0] sample_usec;
    } ptto_in_t;

    // One result item: interpolated time.
    typedef struct packed {
        logic [31:0] time_sec;
        logic [19:0] time_usec;
    } ptto_out_t;

    // Configuration register contents.
    typedef struct packed {
        logic [32:0] base_step;
        logic [31:0] kp_gain;
        logic [31:0] ki_gain;
    } ptto_cfg_t;

    // Request codes. The undefined code behaves as a plain tick.
    localparam logic [1:0] REQ_INIT   = 2'd0;
    localparam logic [1:0] REQ_TICK   = 2'd1;
    localparam logic [1:0] REQ_SAMPLE = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_BASE_STEP = 2'd0;
    localparam logic [1:0] REG_KP_GAIN   = 2'd1;
    localparam logic [1:0] REG_KI_GAIN   = 2'd2;

    // Configuration port widths.
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 64;

    // Reset values and fixed constants.
    localparam logic [32:0]        BASE_STEP_RESET = 33'd4294967;
    localparam logic [32:0]        BASE_STEP_MAX   = 33'h1_0000_0000;
    localparam logic [31:0]        KP_RESET        = 32'd29794658;
    localparam logic [31:0]        KI_RESET        = 32'd2646672;
    localparam logic signed [31:0] INTEG_ONE       = 32'sh0100_0000;
    localparam logic [19:0]        USEC_PER_SEC    = 20'd1000000;
    localparam int                 Q24_SHIFT       = 24;

    // Quotient bits produced by the microsecond divider per cycle.
    localparam int DIV_RADIX_BITS = 4;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_SAMPLE,
        ST_LOAD,
        ST_DIFF,
        ST_ESAT,
        ST_MUL_KI,
        ST_MUL_KP,
        ST_SUM,
        ST_MUL_BS,
        ST_TICK,
        ST_ADVANCE,
        ST_MUL_OUT,
        ST_EMIT
    } ptto_state_t;

    // Operand selection of the shared multiplier.
    typedef enum logic [1:0] {
        MUL_KI,
        MUL_KP,
        MUL_BS,
        MUL_US
    } ptto_mul_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic          capture;
        logic          div_step;
        logic          smp_load;
        logic          init_load;
        logic          diff_load;
        logic          esat_load;
        logic          mul_load;
        ptto_mul_sel_t mul_sel;
        logic          integ_load;
        logic          sum_load;
        logic          tick_load;
        logic          advance;
        logic          out_load;
    } ptto_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] item_req;
        logic [1:0] held_req;
    } ptto_status_t;

endpackage

### src/ptto_regs.sv
`timescale 1ns / 1ps

module ptto_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ptto_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [ptto_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [ptto_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready,
    output ptto_pkg::ptto_cfg_t                  cfg
);
    import ptto_pkg::*;

    logic [32:0] base_step_reg;
    logic [32:0] base_step_next;
    logic [31:0] kp_gain_reg;
    logic [31:0] kp_gain_next;
    logic [31:0] ki_gain_reg;
    logic [31:0] ki_gain_next;
    logic [1:0]  reg_index;
    logic        wr_en;

    // Registers sit on 8-byte boundaries.
    assign reg_index = paddr[4:3];
    assign wr_en     = psel & penable & pwrite;
    assign pready    = 1'b1;

    // Write decode; an oversized base step clamps to one second.
    always_comb
    begin
        base_step_next = base_step_reg;
        kp_gain_next   = kp_gain_reg;
        ki_gain_next   = ki_gain_reg;
        if (wr_en)
        begin
            unique case (reg_index)
                REG_BASE_STEP:
                begin
                    base_step_next = (pwdata[32:0] > BASE_STEP_MAX) ? BASE_STEP_MAX
                                                                    : pwdata[32:0];
                end
                REG_KP_GAIN: kp_gain_next = pwdata[31:0];
                REG_KI_GAIN: ki_gain_next = pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_step_reg <= BASE_STEP_RESET;
            kp_gain_reg   <= KP_RESET;
            ki_gain_reg   <= KI_RESET;
        end
        else
        begin
            base_step_reg <= base_step_next;
            kp_gain_reg   <= kp_gain_next;
            ki_gain_reg   <= ki_gain_next;
        end
    end

    // Read decode.
    always_comb
    begin
        unique case (reg_index)
            REG_BASE_STEP: prdata = {31'b0, base_step_reg};
            REG_KP_GAIN:   prdata = {32'b0, kp_gain_reg};
            REG_KI_GAIN:   prdata = {32'b0, ki_gain_reg};
            default:       prdata = '0;
        endcase
    end

    assign cfg.base_step = base_step_reg;
    assign cfg.kp_gain   = kp_gain_reg;
    assign cfg.ki_gain   = ki_gain_reg;

endmodule

### src/ptto_dpath.sv
`timescale 1ns / 1ps

module ptto_dpath #(
    parameter int FRACTION_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ptto_pkg::ptto_in_t      in_data,
    input  ptto_pkg::ptto_cfg_t     cfg,
    input  ptto_pkg::ptto_cmd_t     cmd,
    output ptto_pkg::ptto_status_t  status,
    output ptto_pkg::ptto_out_t     out_data
);
    import ptto_pkg::*;

    localparam int DivSteps = (FRACTION_BITS + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
    localparam int QW       = DIV_RADIX_BITS * DivSteps;
    localparam int EShr     = (FRACTION_BITS >= Q24_SHIFT) ? FRACTION_BITS - Q24_SHIFT : 0;
    localparam int EShl     = (FRACTION_BITS < Q24_SHIFT) ? Q24_SHIFT - FRACTION_BITS : 0;
    localparam logic [63:0] ELim     = 64'hFFFF_FFFF >> EShl;
    localparam logic [63:0] FracMask = (64'd1 << FRACTION_BITS) - 64'd1;

    // Held item and divider state.
    logic [1:0]  req_reg;
    logic [31:0] sec_reg;
    logic        qhi_reg;
    logic [19:0] rem_reg;
    logic [19:0] rem_next;
    logic [QW-1:0] q_reg;
    logic [QW-1:0] q_next;

    // Servo state.
    logic [63:0]        time_reg;
    logic [63:0]        time_next;
    logic signed [31:0] integ_reg;
    logic signed [31:0] integ_next;
    logic signed [39:0] tick_reg;
    logic signed [39:0] tick_next;

    // Working registers.
    logic [63:0] smp_reg;
    logic [63:0] diff_reg;
    logic [31:0] e_mag_reg;
    logic        e_neg_reg;
    logic [63:0] prod_reg;
    logic        prod_neg_reg;
    logic [31:0] s_mag_reg;
    logic        s_neg_reg;
    ptto_out_t   out_reg;

    // Combinational intermediates.
    logic        usec_ge;
    logic [19:0] usec_rem;
    logic [19:0] div_rem;
    logic [20:0] div_shift;
    logic [DIV_RADIX_BITS-1:0] div_bits;
    logic [63:0] smp_whole;
    logic [63:0] smp_frac;
    logic [63:0] smp_sum;
    logic        e_neg;
    logic [63:0] e_abs;
    logic [63:0] e_scaled;
    logic [31:0] e_clamp;
    logic [31:0] e_mag;
    logic [31:0] mul_a;
    logic [32:0] mul_b;
    logic        mul_neg;
    logic [64:0] mul_full;
    logic [39:0] q_mag;
    logic signed [40:0] q_val;
    logic signed [41:0] integ_sum;
    logic signed [41:0] pi_sum;
    logic signed [31:0] pi_sat;

    // Saturation of a wide signed sum to 32 bits.
    function automatic logic signed [31:0] sat_s32(input logic signed [41:0] v);
        if (v[41:31] != {11{v[41]}})
        begin
            return v[41] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return v[31:0];
    endfunction

    // Saturation of a 41-bit signed value to 40 bits.
    function automatic logic signed [39:0] sat_s40(input logic signed [40:0] v);
        if (v[40] != v[39])
        begin
            return v[40] ? 40'sh80_0000_0000 : 40'sh7F_FFFF_FFFF;
        end
        return v[39:0];
    endfunction

    // Whole seconds of the microsecond sample come out in one compare.
    assign usec_ge  = (in_data.sample_usec >= USEC_PER_SEC);
    assign usec_rem = usec_ge ? (in_data.sample_usec - USEC_PER_SEC) : in_data.sample_usec;

    // Restoring division of the remainder, a few quotient bits per cycle.
    always_comb
    begin
        div_rem   = rem_reg;
        div_shift = '0;
        div_bits  = '0;
        for (int i = 0; i < DIV_RADIX_BITS; i++)
        begin
            div_shift = {div_rem, 1'b0};
            if (div_shift >= {1'b0, USEC_PER_SEC})
            begin
                div_bits[DIV_RADIX_BITS-1-i] = 1'b1;
                div_rem = 20'(div_shift - {1'b0, USEC_PER_SEC});
            end
            else
            begin
                div_rem = div_shift[19:0];
            end
        end
    end

    always_comb
    begin
        rem_next = rem_reg;
        q_next   = q_reg;
        if (cmd.capture)
        begin
            rem_next = usec_rem;
        end
        else if (cmd.div_step)
        begin
            rem_next = div_rem;
            q_next   = {q_reg[QW-DIV_RADIX_BITS-1:0], div_bits};
        end
    end

    // Sample in fixed point; surplus low quotient bits are dropped.
    assign smp_whole = {32'b0, sec_reg} << FRACTION_BITS;
    assign smp_frac  = {{(63 - FRACTION_BITS){1'b0}}, qhi_reg, q_reg[QW-FRACTION_BITS +: FRACTION_BITS]};
    assign smp_sum   = smp_whole + smp_frac;

    // Error magnitude in Q8.24, clamped to the 32-bit signed range.
    assign e_neg = diff_reg[63];
    assign e_abs = e_neg ? (~diff_reg + 64'd1) : diff_reg;

    always_comb
    begin
        if (FRACTION_BITS >= Q24_SHIFT)
        begin
            e_scaled = e_abs >> EShr;
        end
        else
        begin
            e_scaled = (e_abs > ELim) ? 64'hFFFF_FFFF : (e_abs << EShl);
        end
        e_clamp = (e_scaled > 64'h8000_0000) ? 32'h8000_0000 : e_scaled[31:0];
        if (!e_neg && e_clamp == 32'h8000_0000)
        begin
            e_mag = 32'h7FFF_FFFF;
        end
        else
        begin
            e_mag = e_clamp;
        end
    end

    // Shared multiplier operand selection.
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_KI:
            begin
                mul_a   = e_mag_reg;
                mul_b   = {1'b0, cfg.ki_gain};
                mul_neg = e_neg_reg;
            end
            MUL_KP:
            begin
                mul_a   = e_mag_reg;
                mul_b   = {1'b0, cfg.kp_gain};
                mul_neg = e_neg_reg;
            end
            MUL_BS:
            begin
                mul_a   = s_mag_reg;
                mul_b   = cfg.base_step;
                mul_neg = s_neg_reg;
            end
            default:
            begin
                mul_a   = time_reg[31:0] & FracMask[31:0];
                mul_b   = {13'b0, USEC_PER_SEC};
                mul_neg = 1'b0;
            end
        endcase
    end

    assign mul_full = {33'b0, mul_a} * {32'b0, mul_b};

    // Signed product scaled back from Q8.24.
    assign q_mag = prod_reg[63:Q24_SHIFT];
    assign q_val = prod_neg_reg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

    assign integ_sum = {{10{integ_reg[31]}}, integ_reg} + {q_val[40], q_val};
    assign pi_sum    = {{10{integ_reg[31]}}, integ_reg} + {q_val[40], q_val};
    assign pi_sat    = sat_s32(pi_sum);

    // Servo state updates.
    always_comb
    begin
        time_next  = time_reg;
        integ_next = integ_reg;
        tick_next  = tick_reg;
        if (cmd.init_load)
        begin
            time_next  = smp_reg;
            integ_next = INTEG_ONE;
            tick_next  = $signed({7'b0, cfg.base_step});
        end
        else if (cmd.advance)
        begin
            time_next = time_reg + {{24{tick_reg[39]}}, tick_reg};
        end
        if (cmd.integ_load)
        begin
            integ_next = sat_s32(integ_sum);
        end
        if (cmd.tick_load)
        begin
            tick_next = sat_s40(q_val);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg  <= '0;
            integ_reg <= INTEG_ONE;
            tick_reg  <= $signed({7'b0, BASE_STEP_RESET});
        end
        else
        begin
            time_reg  <= time_next;
            integ_reg <= integ_next;
            tick_reg  <= tick_next;
        end
    end

    // Working registers need no reset.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (cmd.capture)
        begin
            req_reg <= in_data.req_type;
            sec_reg <= in_data.sample_sec;
            qhi_reg <= usec_ge;
        end
        if (cmd.smp_load)
        begin
            smp_reg <= smp_sum;
        end
        if (cmd.diff_load)
        begin
            diff_reg <= smp_reg - time_reg;
        end
        if (cmd.esat_load)
        begin
            e_mag_reg <= e_mag;
            e_neg_reg <= e_neg;
        end
        if (cmd.mul_load)
        begin
            prod_reg     <= mul_full[63:0];
            prod_neg_reg <= mul_neg;
        end
        if (cmd.sum_load)
        begin
            s_neg_reg <= pi_sat[31];
            s_mag_reg <= pi_sat[31] ? (~pi_sat + 32'd1) : pi_sat;
        end
        if (cmd.out_load)
        begin
            out_reg.time_sec  <= time_reg[FRACTION_BITS +: 32];
            out_reg.time_usec <= prod_reg[FRACTION_BITS +: 20];
        end
    end

    assign status.item_req = in_data.req_type;
    assign status.held_req = req_reg;
    assign out_data        = out_reg;

endmodule

### src/ptto_ctrl.sv
`timescale 1ns / 1ps

module ptto_ctrl #(
    parameter int FRACTION_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  logic                    out_stall,
    input  ptto_pkg::ptto_status_t  status,
    output ptto_pkg::ptto_cmd_t     cmd
);
    import ptto_pkg::*;

    localparam int DivSteps = (FRACTION_BITS + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
    localparam int CntW     = $clog2(DivSteps);

    ptto_state_t     state_reg;
    ptto_state_t     state_next;
    logic [CntW-1:0] div_cnt_reg;
    logic [CntW-1:0] div_cnt_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    // The result register can take a new item when empty or being drained.
    assign out_free = !out_valid_reg || !out_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (status.item_req == REQ_INIT || status.item_req == REQ_SAMPLE)
                    begin
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_ADVANCE;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    state_next = ST_SAMPLE;
                end
            end
            ST_SAMPLE:  state_next = (status.held_req == REQ_INIT) ? ST_LOAD : ST_DIFF;
            ST_LOAD:    state_next = ST_ADVANCE;
            ST_DIFF:    state_next = ST_ESAT;
            ST_ESAT:    state_next = ST_MUL_KI;
            ST_MUL_KI:  state_next = ST_MUL_KP;
            ST_MUL_KP:  state_next = ST_SUM;
            ST_SUM:     state_next = ST_MUL_BS;
            ST_MUL_BS:  state_next = ST_TICK;
            ST_TICK:    state_next = ST_ADVANCE;
            ST_ADVANCE: state_next = ST_MUL_OUT;
            ST_MUL_OUT: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd      = '0;
        in_stall = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:    cmd.capture = in_valid;
            ST_DIV:     cmd.div_step = 1'b1;
            ST_SAMPLE:  cmd.smp_load = 1'b1;
            ST_LOAD:    cmd.init_load = 1'b1;
            ST_DIFF:    cmd.diff_load = 1'b1;
            ST_ESAT:    cmd.esat_load = 1'b1;
            ST_MUL_KI:
            begin
                cmd.mul_load = 1'b1;
                cmd.mul_sel  = MUL_KI;
            end
            ST_MUL_KP:
            begin
                cmd.mul_load   = 1'b1;
                cmd.mul_sel    = MUL_KP;
                cmd.integ_load = 1'b1;
            end
            ST_SUM:     cmd.sum_load = 1'b1;
            ST_MUL_BS:
            begin
                cmd.mul_load = 1'b1;
                cmd.mul_sel  = MUL_BS;
            end
            ST_TICK:    cmd.tick_load = 1'b1;
            ST_ADVANCE: cmd.advance = 1'b1;
            ST_MUL_OUT:
            begin
                cmd.mul_load = 1'b1;
                cmd.mul_sel  = MUL_US;
            end
            ST_EMIT:    cmd.out_load = out_free;
            default: ;
        endcase
    end

    // Divider step counter.
    always_comb
    begin
        div_cnt_next = div_cnt_reg;
        if (state_reg == ST_IDLE)
        begin
            div_cnt_next = CntW'(DivSteps - 1);
        end
        else if (state_reg == ST_DIV && div_cnt_reg != '0)
        begin
            div_cnt_next = div_cnt_reg - 1'b1;
        end
    end

    // Result valid flag.
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    // An accepted item always starts work.
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != ST_IDLE))
        else $error("accepted item did not start work");

    // The divider runs its full count before the sample is formed.
    a_div_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && div_cnt_reg != '0) |=> (state_reg == ST_DIV))
        else $error("divider left early");

    // A result appears only out of the emit state.
    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result valid raised outside emit");

    // Leaving emit always presents the result.
    a_emit_presents: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_free) |=> out_valid_reg)
        else $error("emitted result not presented");
`endif

endmodule

### src/pi_time_tracking_observer.sv
// PI time-tracking observer: keeps a 32.32 fixed-point clock that advances by a per-tick
// increment on every request item and is steered by a PI loop toward sparse world-time
// samples; each item returns one result with seconds and microseconds of the advanced time.
// Configure base_step, kp_gain and ki_gain at byte addresses 0, 8 and 16 over the 64-bit APB
// port while the block is idle. One item is worked on at a time: a plain tick advances the
// clock and converts the microseconds; an initialise request first runs the microsecond
// divider and loads the sample; a sample tick runs the divider and the PI update first. The
// divider resolves four quotient bits per cycle, and the controller steps the single 32x33
// multiplier through both gain products, the base-step product and the microsecond
// conversion. A finished result waits in an output register while the next item is taken.
`timescale 1ns / 1ps

module pi_time_tracking_observer #(
    parameter int FRACTION_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ptto_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ptto_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ptto_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  ptto_pkg::ptto_in_t               in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output ptto_pkg::ptto_out_t              out_data
);
    import ptto_pkg::*;

    ptto_cfg_t    cfg;
    ptto_cmd_t    cmd;
    ptto_status_t status;

    // Configuration registers.
    ptto_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer.
    ptto_ctrl #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic and servo state.
    ptto_dpath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cfg      (cfg),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

endmodule
